// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the ventilation mode controller.
// Depends on nothing; every macro expects signals clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VMC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vmc assertion failed");

// Next-cycle implication, disabled during reset.
`define VMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vmc assertion failed");

`endif

// ===== hw/rtl/vmc_pkg.sv =====
// Types and constants of the ventilation mode controller.
// Used by vmc_mode_logic and ventilation_mode_controller_top; depends on nothing.
`timescale 1ns / 1ps

package vmc_pkg;

    // Ventilation modes, in the encoding seen on the result fields.
    typedef enum logic [3:0] {
        MODE_INIT     = 4'd0,
        MODE_DAY      = 4'd1,
        MODE_NIGHT    = 4'd2,
        MODE_CO2DAY   = 4'd3,
        MODE_CO2NIGHT = 4'd4,
        MODE_RHDAY    = 4'd5,
        MODE_RHNIGHT  = 4'd6,
        MODE_COOK     = 4'd7,
        MODE_CYCDAY   = 4'd8,
        MODE_CYCNIGHT = 4'd9
    } mode_t;

    // Fan speed codes.
    localparam logic [1:0] FAN_LOW  = 2'd0;
    localparam logic [1:0] FAN_MED  = 2'd1;
    localparam logic [1:0] FAN_HIGH = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CO2_HIGH      = 3'd0;
    localparam logic [2:0] CFG_CO2_LOW       = 3'd1;
    localparam logic [2:0] CFG_RH_HIGH       = 3'd2;
    localparam logic [2:0] CFG_RH_LOW        = 3'd3;
    localparam logic [2:0] CFG_WEEKDAY_START = 3'd4;
    localparam logic [2:0] CFG_WEEKEND_START = 3'd5;
    localparam logic [2:0] CFG_NIGHT_START   = 3'd6;

    // Configuration reset values.
    localparam logic [15:0] CO2_HIGH_RESET      = 16'd1000;
    localparam logic [15:0] CO2_LOW_RESET       = 16'd800;
    localparam logic [9:0]  RH_HIGH_RESET       = 10'd850;
    localparam logic [9:0]  RH_LOW_RESET        = 10'd700;
    localparam logic [4:0]  WEEKDAY_START_RESET = 5'd8;
    localparam logic [4:0]  WEEKEND_START_RESET = 5'd9;
    localparam logic [4:0]  NIGHT_START_RESET   = 5'd21;

    // One tick of readings.
    typedef struct packed {
        logic [4:0]  hour_now;
        logic        is_weekend;
        logic [15:0] co2_ppm;
        logic [9:0]  humidity_tenths;
        logic        cooking_time;
        logic        cycle_time_day;
        logic        cycle_time_night;
        logic        valves_locked;
    } in_item_t;

    // One result per tick.
    typedef struct packed {
        logic [3:0] acting_mode;
        logic [1:0] fan_speed;
        logic       move_valves;
        logic [3:0] next_mode;
    } out_item_t;

    // Threshold and schedule settings.
    typedef struct packed {
        logic [15:0] co2_high_ppm;
        logic [15:0] co2_low_ppm;
        logic [9:0]  rh_high_tenths;
        logic [9:0]  rh_low_tenths;
        logic [4:0]  weekday_start_hour;
        logic [4:0]  weekend_start_hour;
        logic [4:0]  night_start_hour;
    } cfg_t;

endpackage

// ===== hw/rtl/vmc_mode_logic.sv =====
// Combinational mode actions and next-mode selection for one tick.
// Depends on vmc_pkg.
`timescale 1ns / 1ps

module vmc_mode_logic
    import vmc_pkg::*;
(
    input  mode_t     mode,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic [4:0] start_hour;
    logic       day;
    logic       night_hour;
    logic       co2_hi;
    logic       co2_lo;
    logic       rh_hi;
    logic       rh_lo;
    mode_t      act;
    mode_t      next;
    logic [1:0] fan;

    // Threshold compares; hysteresis comes from separate enter and leave levels.
    always_comb
    begin
        start_hour = item.is_weekend ? cfg.weekend_start_hour : cfg.weekday_start_hour;
        day        = (item.hour_now >= start_hour) && (item.hour_now < cfg.night_start_hour);
        night_hour = item.hour_now >= cfg.night_start_hour;
        co2_hi     = item.co2_ppm > cfg.co2_high_ppm;
        co2_lo     = item.co2_ppm < cfg.co2_low_ppm;
        rh_hi      = item.humidity_tenths > cfg.rh_high_tenths;
        rh_lo      = item.humidity_tenths < cfg.rh_low_tenths;
    end

    // Actions of the stored mode and the priority order for the next mode.
    always_comb
    begin
        act  = mode;
        fan  = FAN_LOW;
        next = MODE_INIT;
        unique case (mode)
            MODE_DAY:
            begin
                fan = FAN_MED;
                priority if (night_hour)      next = MODE_NIGHT;
                else if (co2_hi)              next = MODE_CO2DAY;
                else if (rh_hi)               next = MODE_RHDAY;
                else if (item.cooking_time)   next = MODE_COOK;
                else if (item.cycle_time_day) next = MODE_CYCDAY;
                else                          next = MODE_DAY;
            end
            MODE_NIGHT:
            begin
                priority if (day)               next = MODE_DAY;
                else if (co2_hi)                next = MODE_CO2NIGHT;
                else if (rh_hi)                 next = MODE_RHNIGHT;
                else if (item.cycle_time_night) next = MODE_CYCNIGHT;
                else                            next = MODE_NIGHT;
            end
            MODE_CO2DAY:
            begin
                fan = FAN_HIGH;
                priority if (co2_lo) next = MODE_DAY;
                else if (night_hour) next = MODE_CO2NIGHT;
                else                 next = MODE_CO2DAY;
            end
            MODE_CO2NIGHT:
            begin
                priority if (day) next = MODE_CO2DAY;
                else if (co2_lo)  next = MODE_NIGHT;
                else              next = MODE_CO2NIGHT;
            end
            MODE_RHDAY:
            begin
                fan = FAN_HIGH;
                priority if (rh_lo)  next = MODE_DAY;
                else if (night_hour) next = MODE_RHNIGHT;
                else                 next = MODE_RHDAY;
            end
            MODE_RHNIGHT:
            begin
                priority if (rh_lo) next = MODE_NIGHT;
                else if (day)       next = MODE_RHDAY;
                else                next = MODE_RHNIGHT;
            end
            MODE_COOK:
            begin
                fan  = FAN_HIGH;
                next = item.cooking_time ? MODE_COOK : MODE_DAY;
            end
            MODE_CYCDAY:
            begin
                fan = FAN_MED;
                priority if (!item.cycle_time_day) next = MODE_DAY;
                else if (rh_hi)                    next = MODE_RHDAY;
                else if (co2_hi)                   next = MODE_CO2DAY;
                else                               next = MODE_CYCDAY;
            end
            MODE_CYCNIGHT:
            begin
                priority if (!item.cycle_time_night) next = MODE_NIGHT;
                else if (rh_hi)                      next = MODE_RHNIGHT;
                else if (co2_hi)                     next = MODE_CO2NIGHT;
                else                                 next = MODE_CYCNIGHT;
            end
            default:
            begin
                // Init, and any code outside the mode list, behaves as init.
                act  = MODE_INIT;
                next = day ? MODE_DAY : MODE_NIGHT;
            end
        endcase
    end

    // Valve positioning is requested by every mode but init unless the valves are locked.
    always_comb
    begin
        result.acting_mode = act;
        result.fan_speed   = fan;
        result.move_valves = (act != MODE_INIT) && !item.valves_locked;
        result.next_mode   = next;
    end

endmodule

// ===== hw/rtl/ventilation_mode_controller_top.sv =====
// A transaction accepted at the input goes through the input register, then the result register.
// Throughput: one transaction per cycle unless out_ready stalls; the input register feeds the mode logic,
// whose result and mode update are registered in the same cycle.
// Reset (rst_n, asynchronous, active low) sets the init mode and the default
// thresholds and schedule, and empties both pipeline registers.
// Depends on vmc_pkg, vmc_mode_logic and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ventilation_mode_controller_top
    import vmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    mode_t     mode_reg;
    logic      s1_valid_reg;
    in_item_t  s1_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t result;
    logic      s1_advance;
    logic      mode_is_last_next;
    logic      out_acting_init;
    logic      out_fan_high;
    logic      out_high_fan_mode;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CO2_HIGH:      cfg_next.co2_high_ppm       = cfg_data;
                CFG_CO2_LOW:       cfg_next.co2_low_ppm        = cfg_data;
                CFG_RH_HIGH:       cfg_next.rh_high_tenths     = cfg_data[9:0];
                CFG_RH_LOW:        cfg_next.rh_low_tenths      = cfg_data[9:0];
                CFG_WEEKDAY_START: cfg_next.weekday_start_hour = cfg_data[4:0];
                CFG_WEEKEND_START: cfg_next.weekend_start_hour = cfg_data[4:0];
                CFG_NIGHT_START:   cfg_next.night_start_hour   = cfg_data[4:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.co2_high_ppm       <= CO2_HIGH_RESET;
            cfg_reg.co2_low_ppm        <= CO2_LOW_RESET;
            cfg_reg.rh_high_tenths     <= RH_HIGH_RESET;
            cfg_reg.rh_low_tenths      <= RH_LOW_RESET;
            cfg_reg.weekday_start_hour <= WEEKDAY_START_RESET;
            cfg_reg.weekend_start_hour <= WEEKEND_START_RESET;
            cfg_reg.night_start_hour   <= NIGHT_START_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Handshake: the input register moves on whenever the result register is free.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
    end

    vmc_mode_logic u_mode_logic
    (
        .mode   (mode_reg),
        .item   (s1_data_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    // Mode state and result register advance together, one tick per transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                mode_reg <= mode_t'(result.next_mode);
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_data_reg <= result;
        end
    end

    // Terms used by the checks below.
    assign mode_is_last_next = (mode_reg == mode_t'(out_data_reg.next_mode));
    assign out_acting_init   = out_valid_reg && (out_data_reg.acting_mode == MODE_INIT);
    assign out_fan_high      = out_valid_reg && (out_data_reg.fan_speed == FAN_HIGH);
    assign out_high_fan_mode = (out_data_reg.acting_mode == MODE_CO2DAY)
                            || (out_data_reg.acting_mode == MODE_RHDAY)
                            || (out_data_reg.acting_mode == MODE_COOK);

    // The stored mode is always the next mode of the last result produced.
    `VMC_ASSERT_NEXT(a_mode_follows_result, s1_advance, mode_is_last_next)
    // Init never asks for valve positioning.
    `VMC_ASSERT_IMPL(a_init_no_valves, out_acting_init, !out_data_reg.move_valves)
    // High fan speed belongs only to the high CO2 day, high RH day and cooking modes.
    `VMC_ASSERT_IMPL(a_fan_high_modes, out_fan_high, out_high_fan_mode)
    // A held input register must block new transactions.
    `VMC_ASSERT_IMPL(a_full_blocks_input, s1_valid_reg && !s1_advance, !in_ready)

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for ventilation_mode_controller_top: a directed table, then random
// ticks under several threshold settings, checked against a local mode predictor or typed rows.
// Depends on vmc_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_top;
    import vmc_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TICKS_PER_SET   = 115;
    localparam int SETTING_COUNT   = 7;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    // One row of the directed table; want is used only where typed is set.
    typedef struct {
        in_item_t  stim;
        bit        typed;
        out_item_t want;
    } tick_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;

    // Predictor state: thresholds, schedule and the stored mode.
    cfg_t      thresholds;
    mode_t     tracked_mode;
    out_item_t pending_results[$];

    // Expectation typed in by the directed table for the tick now offered.
    bit        row_has_expect;
    out_item_t row_expect;

    tick_row_t dir_rows[$];
    int        max_gap = 10;
    bit        hold_request = 1'b0;
    int        fail_count = 0;
    int        ticks_in = 0;
    int        results_out = 0;
    int        cfg_writes = 0;
    int        idle_cycles = 0;

    // Slowly drifting plant conditions for the random part.
    int walk_hour = 7;
    int walk_co2 = 600;
    int walk_rh = 500;
    bit walk_wk, walk_cook, walk_cycd, walk_cycn, walk_lock;

    ventilation_mode_controller_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Builds one tick of readings from plain numbers.
    function automatic in_item_t reading(int hour, int wk, int co2, int rh,
                                         int cook, int cycd, int cycn, int lock);
        in_item_t r;
        r.hour_now         = hour[4:0];
        r.is_weekend       = wk[0];
        r.co2_ppm          = co2[15:0];
        r.humidity_tenths  = rh[9:0];
        r.cooking_time     = cook[0];
        r.cycle_time_day   = cycd[0];
        r.cycle_time_night = cycn[0];
        r.valves_locked    = lock[0];
        return r;
    endfunction

    // Register value with random bits above the register width, which the block drops.
    function automatic logic [15:0] with_junk(int value, int width);
        logic [15:0] junk;
        logic [15:0] keep;
        junk = 16'($urandom);
        keep = 16'((32'd1 << width) - 1);
        return (junk & ~keep) | (value[15:0] & keep);
    endfunction

    // Works out the acting mode, fan, valve request and next mode for one tick.
    function automatic out_item_t ventilation_step(in_item_t t);
        out_item_t r;
        logic [4:0] start;
        logic day, night_hr, co2_hi, co2_lo, rh_hi, rh_lo;
        mode_t act, nxt;
        start    = t.is_weekend ? thresholds.weekend_start_hour : thresholds.weekday_start_hour;
        day      = (t.hour_now >= start) && (t.hour_now < thresholds.night_start_hour);
        night_hr = t.hour_now >= thresholds.night_start_hour;
        co2_hi   = t.co2_ppm > thresholds.co2_high_ppm;
        co2_lo   = t.co2_ppm < thresholds.co2_low_ppm;
        rh_hi    = t.humidity_tenths > thresholds.rh_high_tenths;
        rh_lo    = t.humidity_tenths < thresholds.rh_low_tenths;
        act      = (tracked_mode > MODE_CYCNIGHT) ? MODE_INIT : tracked_mode;
        r.fan_speed = FAN_LOW;
        case (act)
            MODE_DAY:
            begin
                r.fan_speed = FAN_MED;
                if (night_hr) nxt = MODE_NIGHT;
                else if (co2_hi) nxt = MODE_CO2DAY;
                else if (rh_hi) nxt = MODE_RHDAY;
                else if (t.cooking_time) nxt = MODE_COOK;
                else if (t.cycle_time_day) nxt = MODE_CYCDAY;
                else nxt = MODE_DAY;
            end
            MODE_NIGHT:
            begin
                if (day) nxt = MODE_DAY;
                else if (co2_hi) nxt = MODE_CO2NIGHT;
                else if (rh_hi) nxt = MODE_RHNIGHT;
                else if (t.cycle_time_night) nxt = MODE_CYCNIGHT;
                else nxt = MODE_NIGHT;
            end
            MODE_CO2DAY:
            begin
                r.fan_speed = FAN_HIGH;
                if (co2_lo) nxt = MODE_DAY;
                else if (night_hr) nxt = MODE_CO2NIGHT;
                else nxt = MODE_CO2DAY;
            end
            MODE_CO2NIGHT:
            begin
                if (day) nxt = MODE_CO2DAY;
                else if (co2_lo) nxt = MODE_NIGHT;
                else nxt = MODE_CO2NIGHT;
            end
            MODE_RHDAY:
            begin
                r.fan_speed = FAN_HIGH;
                if (rh_lo) nxt = MODE_DAY;
                else if (night_hr) nxt = MODE_RHNIGHT;
                else nxt = MODE_RHDAY;
            end
            MODE_RHNIGHT:
            begin
                if (rh_lo) nxt = MODE_NIGHT;
                else if (day) nxt = MODE_RHDAY;
                else nxt = MODE_RHNIGHT;
            end
            MODE_COOK:
            begin
                r.fan_speed = FAN_HIGH;
                nxt = t.cooking_time ? MODE_COOK : MODE_DAY;
            end
            MODE_CYCDAY:
            begin
                r.fan_speed = FAN_MED;
                if (!t.cycle_time_day) nxt = MODE_DAY;
                else if (rh_hi) nxt = MODE_RHDAY;
                else if (co2_hi) nxt = MODE_CO2DAY;
                else nxt = MODE_CYCDAY;
            end
            MODE_CYCNIGHT:
            begin
                if (!t.cycle_time_night) nxt = MODE_NIGHT;
                else if (rh_hi) nxt = MODE_RHNIGHT;
                else if (co2_hi) nxt = MODE_CO2NIGHT;
                else nxt = MODE_CYCNIGHT;
            end
            default:
            begin
                nxt = day ? MODE_DAY : MODE_NIGHT;
            end
        endcase
        r.acting_mode = act;
        r.move_valves = (act != MODE_INIT) && !t.valves_locked;
        r.next_mode   = nxt;
        return r;
    endfunction

    // Mostly drifting, plausible readings near the thresholds; now and then pure noise.
    function automatic in_item_t random_tick();
        logic [63:0] noise;
        int step;
        if ($urandom_range(0, 9) == 0)
        begin
            noise = {$urandom, $urandom};
            return noise[35:0];
        end
        if ($urandom_range(0, 29) == 0)
            walk_hour = $urandom_range(0, 23);
        else if ($urandom_range(0, 5) == 0)
            walk_hour = (walk_hour + 1) % 24;
        if ($urandom_range(0, 15) == 0) walk_wk = ~walk_wk;
        if ($urandom_range(0, 5) == 0) walk_cook = ~walk_cook;
        if ($urandom_range(0, 5) == 0) walk_cycd = ~walk_cycd;
        if ($urandom_range(0, 5) == 0) walk_cycn = ~walk_cycn;
        if ($urandom_range(0, 3) == 0) walk_lock = ~walk_lock;
        // CO2 drifts, and sometimes lands on or next to an enter or leave threshold.
        step = $urandom_range(0, 300);
        walk_co2 = walk_co2 + step - 150;
        if ($urandom_range(0, 7) == 0)
        begin
            step = $urandom_range(0, 2);
            walk_co2 = ($urandom_range(0, 1) ? int'(thresholds.co2_high_ppm)
                                             : int'(thresholds.co2_low_ppm)) + step - 1;
        end
        if (walk_co2 < 0) walk_co2 = 0;
        if (walk_co2 > 65535) walk_co2 = 65535;
        // Humidity does the same around its own thresholds.
        step = $urandom_range(0, 120);
        walk_rh = walk_rh + step - 60;
        if ($urandom_range(0, 7) == 0)
        begin
            step = $urandom_range(0, 2);
            walk_rh = ($urandom_range(0, 1) ? int'(thresholds.rh_high_tenths)
                                            : int'(thresholds.rh_low_tenths)) + step - 1;
        end
        if (walk_rh < 0) walk_rh = 0;
        if (walk_rh > 1023) walk_rh = 1023;
        return reading(walk_hour, walk_wk, walk_co2, walk_rh,
                       walk_cook, walk_cycd, walk_cycn, walk_lock);
    endfunction

    // Offers one tick after a random gap and returns once it is accepted.
    task automatic send_tick(in_item_t t, bit typed, out_item_t want);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= t;
        row_has_expect = typed;
        row_expect = want;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stops offering ticks and waits until every expected result is back.
    task automatic go_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write transaction.
    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_thresholds(logic [15:0] co2h, logic [15:0] co2l, logic [15:0] rhh,
                                    logic [15:0] rhl, logic [15:0] wd, logic [15:0] we,
                                    logic [15:0] ns);
        write_reg(CFG_CO2_HIGH, co2h);
        write_reg(CFG_CO2_LOW, co2l);
        write_reg(CFG_RH_HIGH, rhh);
        write_reg(CFG_RH_LOW, rhl);
        write_reg(CFG_WEEKDAY_START, wd);
        write_reg(CFG_WEEKEND_START, we);
        write_reg(CFG_NIGHT_START, ns);
    endtask

    // Receiver: random stalls per result, plus one long hold-off on request.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                gap = $urandom_range(0, max_gap);
                if (gap > 0)
                begin
                    @(negedge clk);
                    out_ready <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Monitor: tracks register writes, predicts on each accepted tick, checks each result.
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = out_data;
                results_out++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with no tick waiting, got acting %0d next %0d",
                             $time, got.acting_mode, got.next_mode);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.acting_mode !== want.acting_mode)
                    begin
                        $display("%0t: acting_mode mismatch, expected %0d, actual %0d",
                                 $time, want.acting_mode, got.acting_mode);
                        fail_count++;
                    end
                    if (got.fan_speed !== want.fan_speed)
                    begin
                        $display("%0t: fan_speed mismatch, expected %0d, actual %0d",
                                 $time, want.fan_speed, got.fan_speed);
                        fail_count++;
                    end
                    if (got.move_valves !== want.move_valves)
                    begin
                        $display("%0t: move_valves mismatch, expected %0d, actual %0d",
                                 $time, want.move_valves, got.move_valves);
                        fail_count++;
                    end
                    if (got.next_mode !== want.next_mode)
                    begin
                        $display("%0t: next_mode mismatch, expected %0d, actual %0d",
                                 $time, want.next_mode, got.next_mode);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                want = ventilation_step(in_data);
                tracked_mode = mode_t'(want.next_mode);
                if (row_has_expect)
                    want = row_expect;
                pending_results.push_back(want);
                ticks_in++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CO2_HIGH:      thresholds.co2_high_ppm = cfg_data;
                    CFG_CO2_LOW:       thresholds.co2_low_ppm = cfg_data;
                    CFG_RH_HIGH:       thresholds.rh_high_tenths = cfg_data[9:0];
                    CFG_RH_LOW:        thresholds.rh_low_tenths = cfg_data[9:0];
                    CFG_WEEKDAY_START: thresholds.weekday_start_hour = cfg_data[4:0];
                    CFG_WEEKEND_START: thresholds.weekend_start_hour = cfg_data[4:0];
                    CFG_NIGHT_START:   thresholds.night_start_hour = cfg_data[4:0];
                    default: ;
                endcase
                cfg_writes++;
            end
        end
    end

    // Watchdog: ends the run when no transaction of any kind happens for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
            $display("FAIL");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then random ticks under each setting.
    initial
    begin
        int i;
        int p;
        int k;
        int co2h;
        int rhh;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        row_has_expect = 1'b0;
        row_expect = '0;
        tracked_mode = MODE_INIT;
        thresholds.co2_high_ppm = CO2_HIGH_RESET;
        thresholds.co2_low_ppm = CO2_LOW_RESET;
        thresholds.rh_high_tenths = RH_HIGH_RESET;
        thresholds.rh_low_tenths = RH_LOW_RESET;
        thresholds.weekday_start_hour = WEEKDAY_START_RESET;
        thresholds.weekend_start_hour = WEEKEND_START_RESET;
        thresholds.night_start_hour = NIGHT_START_RESET;

        // Directed table, valid for the reset thresholds and the init mode.
        dir_rows.push_back('{reading(12, 0, 500, 500, 0, 0, 0, 0), 1'b1,
                             out_item_t'{MODE_INIT, FAN_LOW, 1'b0, MODE_DAY}});
        dir_rows.push_back('{reading(12, 0, 1001, 500, 0, 0, 0, 0), 1'b1,
                             out_item_t'{MODE_DAY, FAN_MED, 1'b1, MODE_CO2DAY}});
        dir_rows.push_back('{reading(12, 0, 800, 500, 0, 0, 0, 0), 1'b1,
                             out_item_t'{MODE_CO2DAY, FAN_HIGH, 1'b1, MODE_CO2DAY}});
        dir_rows.push_back('{reading(12, 0, 799, 500, 0, 0, 0, 0), 1'b1,
                             out_item_t'{MODE_CO2DAY, FAN_HIGH, 1'b1, MODE_DAY}});
        dir_rows.push_back('{reading(12, 0, 500, 851, 0, 0, 0, 0), 1'b1,
                             out_item_t'{MODE_DAY, FAN_MED, 1'b1, MODE_RHDAY}});
        dir_rows.push_back('{reading(21, 0, 500, 700, 0, 0, 0, 0), 1'b1,
                             out_item_t'{MODE_RHDAY, FAN_HIGH, 1'b1, MODE_RHNIGHT}});
        dir_rows.push_back('{reading(22, 0, 500, 699, 0, 0, 0, 1), 1'b1,
                             out_item_t'{MODE_RHNIGHT, FAN_LOW, 1'b0, MODE_NIGHT}});
        dir_rows.push_back('{reading(22, 0, 500, 500, 0, 0, 1, 0), 1'b0, '0});
        dir_rows.push_back('{reading(23, 0, 500, 900, 0, 0, 1, 0), 1'b0, '0});
        dir_rows.push_back('{reading(8, 0, 500, 800, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{reading(8, 0, 500, 600, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{reading(10, 0, 500, 500, 1, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{reading(10, 0, 65535, 1023, 1, 0, 0, 1), 1'b1,
                             out_item_t'{MODE_COOK, FAN_HIGH, 1'b0, MODE_COOK}});
        dir_rows.push_back('{reading(10, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{reading(10, 0, 0, 0, 0, 1, 0, 0), 1'b0, '0});
        dir_rows.push_back('{reading(11, 0, 1500, 0, 0, 1, 0, 0), 1'b0, '0});
        dir_rows.push_back('{reading(21, 1, 1500, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{reading(9, 1, 1500, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{reading(3, 1, 1500, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{reading(3, 1, 100, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{reading(31, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{reading(8, 1, 2000, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{reading(30, 0, 100, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{reading(22, 0, 0, 0, 0, 0, 1, 0), 1'b0, '0});
        dir_rows.push_back('{reading(22, 0, 2000, 0, 0, 0, 1, 0), 1'b0, '0});

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < dir_rows.size(); i++)
            send_tick(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

        for (p = 0; p < SETTING_COUNT; p++)
        begin
            if (p > 0)
                go_idle();
            // Setting 0 keeps the reset values; 1 and 5 use random values, 2 to 4 extreme ones, 6 the reset values.
            max_gap = (p == 2 || p == 4) ? 0 : 10;
            case (p)
                1, 5:
                begin
                    co2h = $urandom_range(300, 3000);
                    rhh = $urandom_range(400, 1000);
                    apply_thresholds(16'(co2h), 16'($urandom_range(200, co2h)),
                                     with_junk(rhh, 10),
                                     with_junk($urandom_range(300, rhh), 10),
                                     with_junk($urandom_range(0, 23), 5),
                                     with_junk($urandom_range(0, 23), 5),
                                     with_junk($urandom_range(0, 24), 5));
                    write_reg(CFG_UNUSED, 16'($urandom));
                end
                2: apply_thresholds(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                3: apply_thresholds(16'd40000, 16'd40000, 16'd1000, 16'd1000,
                                    16'd23, 16'd23, 16'd24);
                4: apply_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF, 16'hFFFF, 16'hFFFF);
                6: apply_thresholds(CO2_HIGH_RESET, CO2_LOW_RESET, 16'(RH_HIGH_RESET),
                                    16'(RH_LOW_RESET), 16'(WEEKDAY_START_RESET),
                                    16'(WEEKEND_START_RESET), 16'(NIGHT_START_RESET));
                default: ;
            endcase
            for (k = 0; k < TICKS_PER_SET; k++)
            begin
                send_tick(random_tick(), 1'b0, '0);
                // Long receiver hold-off while ticks keep coming, so the input stalls.
                if (p == 1 && k == 40)
                    hold_request = 1'b1;
                // Sender pause until the pipeline has drained.
                if (p == 5 && k == 60)
                    go_idle();
            end
        end

        go_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d ticks and %0d results over %0d threshold settings,",
                 ticks_in, results_out, SETTING_COUNT);
        $display("with %0d register writes, random stalls and one long output hold-off.",
                 cfg_writes);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
